// ===== rtl/quadrature_detent_value_counter_assert.svh =====
// Assertion macros shared by the checker of the quadrature detent value counter.
// Depends on nothing; the including file supplies clock, reset and expressions.
`ifndef QUADRATURE_DETENT_VALUE_COUNTER_ASSERT_SVH
`define QUADRATURE_DETENT_VALUE_COUNTER_ASSERT_SVH

// Same-cycle implication; the consequent may itself carry a ## delay.
`define QDVC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qdvc check failed");

// Next-cycle implication.
`define QDVC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qdvc check failed");

`endif

// ===== rtl/qdvc_pkg.sv =====
// Shared types, operation codes and helper functions for the detent value counter.
// Depends on nothing; imported by every module of the block.
package qdvc_pkg;

  localparam int OP_W        = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int FIELD_W     = 16;
  localparam int STEP_W      = 15;
  localparam int PARTIAL_W   = 3;

  localparam logic [OP_W-1:0] OP_SAMPLE = 3'd0;
  localparam logic [OP_W-1:0] OP_TICK   = 3'd1;
  localparam logic [OP_W-1:0] OP_SET    = 3'd2;
  localparam logic [OP_W-1:0] OP_ZERO   = 3'd3;
  localparam logic [OP_W-1:0] OP_REPORT = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_VALUE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_VALUE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_SIZE = 2'd2;

  localparam logic signed [1:0] MOVE_NONE = 2'sb00;
  localparam logic signed [1:0] MOVE_FWD  = 2'sb01;
  localparam logic signed [1:0] MOVE_REV  = 2'sb11;

  // Strobes for the item being processed this cycle; at most one is set.
  typedef struct packed {
    logic sample;
    logic tick;
    logic set;
    logic zero;
  } qdvc_ctrl_t;

  // Quarter-step move from previous {A,B} to new {A,B}.
  function automatic logic signed [1:0] qdvc_move(input logic [3:0] idx);
    logic signed [1:0] m;
    unique case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: m = MOVE_REV;
      4'd2, 4'd4, 4'd11, 4'd13: m = MOVE_FWD;
      default: m = MOVE_NONE;
    endcase
    return m;
  endfunction

  function automatic logic signed [FIELD_W-1:0] qdvc_clamp(
    input logic signed [31:0]        v,
    input logic signed [FIELD_W-1:0] lo,
    input logic signed [FIELD_W-1:0] hi
  );
    logic signed [31:0] lo_x;
    logic signed [31:0] hi_x;
    logic signed [FIELD_W-1:0] r;
    lo_x = 32'(lo);
    hi_x = 32'(hi);
    if (v < lo_x) begin
      r = lo;
    end else if (v > hi_x) begin
      r = hi;
    end else begin
      r = v[FIELD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/quadrature_detent_value_counter.sv =====
// Quadrature detent value counter, top level: input register, phase tracker,
// value unit and result register. Depends on qdvc_pkg, qdvc_phase_acc, qdvc_value_unit.
// Path: an item is taken into the input register and its result is then loaded into
// the result register, which raises result_valid; a full result register can hold it back.
// Throughput: one item per cycle; a waiting result holds the next result item, so item_ready follows result_ready.
// Reset (rst, synchronous): bounds 0..127, step 1, value 0, switch released, no item held.
module quadrature_detent_value_counter #(
  parameter int VALUE_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // item channel
  input  logic                                    item_valid,
  output logic                                    item_ready,
  input  logic [qdvc_pkg::OP_W-1:0]               operation,
  input  logic                                    phase_a,
  input  logic                                    phase_b,
  input  logic                                    switch_level,
  input  logic signed [qdvc_pkg::FIELD_W-1:0]     new_value,
  // result channel
  output logic                                    result_valid,
  input  logic                                    result_ready,
  output logic signed [qdvc_pkg::FIELD_W-1:0]     value,
  output logic                                    value_changed,
  output logic                                    switch_state,
  // configuration write channel
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [qdvc_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [qdvc_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import qdvc_pkg::*;

  // Input register.
  logic                      s1_valid;
  logic [OP_W-1:0]           s1_op;
  logic                      s1_a;
  logic                      s1_b;
  logic                      s1_sw;
  logic signed [FIELD_W-1:0] s1_nv;

  logic                      s1_has_result;
  logic                      out_free;
  logic                      s1_go;
  logic                      item_xfer;
  logic                      cfg_we;
  qdvc_ctrl_t                ctrl;

  logic signed [FIELD_W-1:0] pending;
  logic                      held_switch;
  logic signed [FIELD_W-1:0] value_next;
  logic                      changed;

  // Tick, set, zero and report each give one result; sample and unused codes none.
  assign s1_has_result = (s1_op == OP_TICK) || (s1_op == OP_SET) ||
                         (s1_op == OP_ZERO) || (s1_op == OP_REPORT);

  // The result register is free when empty or being drained this cycle.
  assign out_free = !result_valid || result_ready;

  // Advance the held item unless it needs the result register and that is full.
  assign s1_go      = s1_valid && (!s1_has_result || out_free);
  assign item_ready = !s1_valid || s1_go;
  assign item_xfer  = item_valid && item_ready;

  // Always taken; the user must make configuration arrive only while the block is idle (not checked here).
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_comb begin
    ctrl.sample = s1_go && (s1_op == OP_SAMPLE);
    ctrl.tick   = s1_go && (s1_op == OP_TICK);
    ctrl.set    = s1_go && (s1_op == OP_SET);
    ctrl.zero   = s1_go && (s1_op == OP_ZERO);
  end

  // Hold the item until it is processed; load the next one on the same edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_xfer) begin
      s1_op <= operation;
      s1_a  <= phase_a;
      s1_b  <= phase_b;
      s1_sw <= switch_level;
      s1_nv <= new_value;
    end
  end

  qdvc_phase_acc u_phase_acc (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .phase_a      (s1_a),
    .phase_b      (s1_b),
    .switch_level (s1_sw),
    .pending      (pending),
    .held_switch  (held_switch)
  );

  qdvc_value_unit #(
    .VALUE_BITS (VALUE_BITS)
  ) u_value_unit (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .pending    (pending),
    .new_value  (s1_nv),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .value_next (value_next),
    .changed    (changed)
  );

  // Result register: load on a result-producing item, drop valid on transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_go && s1_has_result) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // Switch level is unchanged by result-producing items, so the held copy is current.
  always_ff @(posedge clk) begin
    if (s1_go && s1_has_result) begin
      value         <= value_next;
      value_changed <= changed;
      switch_state  <= held_switch;
    end
  end

endmodule

// ===== rtl/qdvc_phase_acc.sv =====
// Phase tracker: transition table lookup and saturating pending quarter count.
// Depends on qdvc_pkg.
module qdvc_phase_acc (
  input  logic                                 clk,
  input  logic                                 rst,
  input  qdvc_pkg::qdvc_ctrl_t                 ctrl,
  input  logic                                 phase_a,
  input  logic                                 phase_b,
  input  logic                                 switch_level,
  output logic signed [qdvc_pkg::FIELD_W-1:0]  pending,
  output logic                                 held_switch
);
  import qdvc_pkg::*;

  logic [1:0]                previous_phase;
  logic                      phase_primed;
  logic signed [1:0]         move;
  logic signed [FIELD_W:0]   pend_sum;
  logic signed [FIELD_W-1:0] pend_sat;

  assign move     = qdvc_move({previous_phase, phase_a, phase_b});
  assign pend_sum = (FIELD_W+1)'(pending) + (FIELD_W+1)'(move);

  // Saturate on overflow of the signed count.
  always_comb begin
    if (pend_sum[FIELD_W] != pend_sum[FIELD_W-1]) begin
      pend_sat = pend_sum[FIELD_W] ? {1'b1, {(FIELD_W-1){1'b0}}}
                                   : {1'b0, {(FIELD_W-1){1'b1}}};
    end else begin
      pend_sat = pend_sum[FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_phase <= 2'b00;
      phase_primed   <= 1'b0;
      pending        <= '0;
      held_switch    <= 1'b1;
    end else if (ctrl.sample) begin
      held_switch    <= switch_level;
      if (phase_primed) begin
        pending <= pend_sat;
      end
      previous_phase <= {phase_a, phase_b};
      phase_primed   <= 1'b1;
    end else if (ctrl.tick) begin
      pending <= '0;
    end
  end

endmodule

// ===== rtl/qdvc_value_unit.sv =====
// Value unit: detent extraction, step multiply, bound clamp and bound registers.
// Depends on qdvc_pkg.
module qdvc_value_unit #(
  parameter int VALUE_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  qdvc_pkg::qdvc_ctrl_t                    ctrl,
  input  logic signed [qdvc_pkg::FIELD_W-1:0]     pending,
  input  logic signed [qdvc_pkg::FIELD_W-1:0]     new_value,
  input  logic                                    cfg_we,
  input  logic [qdvc_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [qdvc_pkg::CFG_DATA_W-1:0]         cfg_data,
  output logic signed [qdvc_pkg::FIELD_W-1:0]     value_next,
  output logic                                    changed
);
  import qdvc_pkg::*;

  localparam int LimHiInt = (VALUE_BITS >= FIELD_W) ? ((1 << (FIELD_W-1)) - 1)
                                                    : ((1 << (VALUE_BITS-1)) - 1);
  localparam logic signed [FIELD_W-1:0] LIM_HI = FIELD_W'(LimHiInt);
  localparam logic signed [FIELD_W-1:0] LIM_LO = FIELD_W'(-LimHiInt - 1);

  logic signed [FIELD_W-1:0]   min_value;
  logic signed [FIELD_W-1:0]   max_value;
  logic [STEP_W-1:0]           step_size;
  logic signed [PARTIAL_W-1:0] partial;
  logic signed [FIELD_W-1:0]   held;

  logic signed [FIELD_W:0]     tick_sum;
  logic signed [FIELD_W:0]     tick_adj;
  logic signed [FIELD_W-2:0]   detents;
  logic signed [FIELD_W:0]     rem_full;
  logic signed [30:0]          delta;
  logic signed [31:0]          tick_target;
  logic signed [FIELD_W-1:0]   lo_now;
  logic signed [FIELD_W-1:0]   hi_now;
  logic signed [PARTIAL_W-1:0] partial_next;

  logic signed [FIELD_W-1:0]   cfg_word;
  logic signed [FIELD_W-1:0]   min_new;
  logic signed [FIELD_W-1:0]   max_new;
  logic signed [FIELD_W-1:0]   held_cfg;

  function automatic logic signed [FIELD_W-1:0] lim(input logic signed [FIELD_W-1:0] b);
    logic signed [FIELD_W-1:0] r;
    if (b < LIM_LO) begin
      r = LIM_LO;
    end else if (b > LIM_HI) begin
      r = LIM_HI;
    end else begin
      r = b;
    end
    return r;
  endfunction

  assign lo_now = lim(min_value);
  assign hi_now = lim(max_value);

  // Truncate toward zero: bias negative sums by 3 before the shift.
  assign tick_sum    = (FIELD_W+1)'(pending) + (FIELD_W+1)'(partial);
  assign tick_adj    = tick_sum + (tick_sum[FIELD_W] ? (FIELD_W+1)'(3) : (FIELD_W+1)'(0));
  assign detents     = tick_adj[FIELD_W:2];
  assign rem_full    = tick_sum - (FIELD_W+1)'({detents, 2'b00});
  assign delta       = 31'(detents) * 31'($signed({1'b0, step_size}));
  assign tick_target = 32'(held) + 32'(delta);

  always_comb begin
    value_next   = held;
    partial_next = partial;
    changed      = 1'b0;
    priority if (ctrl.tick) begin
      partial_next = rem_full[PARTIAL_W-1:0];
      if (detents != '0) begin
        value_next = qdvc_clamp(tick_target, lo_now, hi_now);
        changed    = 1'b1;
      end
    end else if (ctrl.set) begin
      value_next   = qdvc_clamp(32'(new_value), lo_now, hi_now);
      partial_next = '0;
      changed      = 1'b1;
    end else if (ctrl.zero) begin
      value_next   = qdvc_clamp(32'sd0, lo_now, hi_now);
      partial_next = '0;
      changed      = 1'b1;
    end
  end

  // Bound writes: swap when the new bound passes the other, then reclamp.
  assign cfg_word = cfg_data;
  always_comb begin
    min_new = min_value;
    max_new = max_value;
    if (cfg_index == CFG_MIN_VALUE) begin
      if (cfg_word > max_value) begin
        min_new = max_value;
        max_new = cfg_word;
      end else begin
        min_new = cfg_word;
      end
    end else if (cfg_index == CFG_MAX_VALUE) begin
      if (cfg_word < min_value) begin
        max_new = min_value;
        min_new = cfg_word;
      end else begin
        max_new = cfg_word;
      end
    end
    held_cfg = qdvc_clamp(32'(held), lim(min_new), lim(max_new));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_value <= '0;
      max_value <= FIELD_W'(127);
      step_size <= STEP_W'(1);
      partial   <= '0;
      held      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_VALUE, CFG_MAX_VALUE: begin
          min_value <= min_new;
          max_value <= max_new;
          held      <= held_cfg;
        end
        CFG_STEP_SIZE: begin
          if (cfg_data[STEP_W-1:0] != '0) begin
            step_size <= cfg_data[STEP_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end else begin
      held    <= value_next;
      partial <= partial_next;
    end
  end

endmodule

// ===== rtl/qdvc_checker.sv =====
// Port-level checks for the quadrature detent value counter, bound to the top level.
// Depends on qdvc_pkg and quadrature_detent_value_counter_assert.svh.
`include "quadrature_detent_value_counter_assert.svh"

module qdvc_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 item_valid,
  input logic                                 item_ready,
  input logic [qdvc_pkg::OP_W-1:0]            operation,
  input logic                                 result_valid,
  input logic                                 result_ready,
  input logic signed [qdvc_pkg::FIELD_W-1:0]  value,
  input logic                                 value_changed,
  input logic                                 switch_state,
  input logic                                 cfg_valid,
  input logic                                 cfg_ready
);
  import qdvc_pkg::*;

  logic result_op;

  assign result_op = (operation == OP_TICK) || (operation == OP_SET) ||
                     (operation == OP_ZERO) || (operation == OP_REPORT);

  // A stalled result keeps its payload.
  `QDVC_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(value) && $stable(value_changed) && $stable(switch_state))

  // No result is offered right after reset.
  `QDVC_ASSERT_NOW(a_reset_empty, clk, rst, $past(rst), !result_valid)

  // A result-producing item shows up on the result channel after the input and result registers.
  `QDVC_ASSERT_NOW(a_result_latency, clk, rst, item_valid && item_ready && result_op, ##2 result_valid)

  // Configuration writes are never stalled.
  `QDVC_ASSERT_NOW(a_cfg_taken, clk, rst, cfg_valid, cfg_ready)

endmodule

bind quadrature_detent_value_counter qdvc_checker u_qdvc_checker (.*);
